// ----- hw/rtl/i2cdbw_pkg.sv -----
// Shared types and constants for the I2C display byte writer.
// Holds phase codes, tick-state and result structs. No dependencies.
`timescale 1ns / 1ps
package i2cdbw_pkg;

    localparam logic [2:0] PH_IDLE     = 3'd0;
    localparam logic [2:0] PH_START    = 3'd1;
    localparam logic [2:0] PH_BIT      = 3'd2;
    localparam logic [2:0] PH_ACK_REL  = 3'd3;
    localparam logic [2:0] PH_ACK_POLL = 3'd4;
    localparam logic [2:0] PH_ACK_END  = 3'd5;
    localparam logic [2:0] PH_STOP     = 3'd6;

    localparam logic [7:0] CTRL_CMD      = 8'h00;
    localparam logic [7:0] CTRL_DATA     = 8'h40;
    localparam logic [7:0] ADDR_RESET    = 8'h78;
    localparam logic [7:0] TIMEOUT_RESET = 8'd200;

    localparam logic [1:0] BYTE_ADDR = 2'd0;
    localparam logic [1:0] BYTE_CTRL = 2'd1;
    localparam logic [1:0] BYTE_LAST = 2'd2;

    localparam int CFG_INDEX_W = 8;
    localparam logic [CFG_INDEX_W-1:0] REG_DEVICE_ADDRESS = 8'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_ACK_TIMEOUT    = 8'd1;

    typedef struct packed {
        logic [2:0] phase;
        logic [1:0] byte_index;
        logic [2:0] bit_index;
        logic [1:0] tick_in_bit;
        logic [7:0] shift_byte;
        logic [7:0] wait_count;
        logic [7:0] held_payload;
        logic       held_is_data;
        logic       nack_flag;
        logic       scl;
        logic       sda;
    } tick_state_t;

    typedef struct packed {
        logic scl_level;
        logic sda_level;
        logic busy_res;
        logic nack_seen;
        logic done_res;
    } tick_result_t;

    typedef struct packed {
        logic [7:0] device_address;
        logic [7:0] ack_timeout;
    } cfg_t;

    localparam tick_state_t STATE_RESET = '{
        phase: PH_IDLE, byte_index: 2'd0, bit_index: 3'd0, tick_in_bit: 2'd0,
        shift_byte: 8'd0, wait_count: 8'd0, held_payload: 8'd0,
        held_is_data: 1'b0, nack_flag: 1'b0, scl: 1'b1, sda: 1'b1
    };

endpackage

// ----- hw/rtl/i2cdbw_cfg_regs.sv -----
// Configuration register file: device address and ack timeout.
// Depends on i2cdbw_pkg.
`timescale 1ns / 1ps
module i2cdbw_cfg_regs
    import i2cdbw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   cfg_valid,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            case (cfg_index)
                REG_DEVICE_ADDRESS: cfg_next.device_address = cfg_data;
                REG_ACK_TIMEOUT:    cfg_next.ack_timeout    = cfg_data;
                default:            cfg_next = cfg_reg;  // drop unknown index
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.device_address <= ADDR_RESET;
            cfg_reg.ack_timeout    <= TIMEOUT_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ----- hw/rtl/i2cdbw_tick_step.sv -----
// Combinational next-tick logic of the I2C write sequencer.
// Depends on i2cdbw_pkg.
`timescale 1ns / 1ps
module i2cdbw_tick_step
    import i2cdbw_pkg::*;
(
    input  tick_state_t  cur,
    input  cfg_t         cfg,
    input  logic         start_request,
    input  logic         is_data,
    input  logic [7:0]   payload,
    input  logic         sda_in,
    output tick_state_t  nxt,
    output tick_result_t res
);

    function automatic logic [7:0] pick_byte(input logic [1:0] idx, input logic held_data,
                                             input logic [7:0] held_pl,
                                             input logic [7:0] addr);
        logic [7:0] b;
        case (idx)
            BYTE_ADDR: b = addr;
            BYTE_CTRL: b = held_data ? CTRL_DATA : CTRL_CMD;
            default:   b = held_pl;
        endcase
        return b;
    endfunction

    tick_state_t st;
    logic [2:0]  ph;
    logic        busy;
    logic        done;

    always_comb begin
        st   = cur;
        busy = 1'b1;
        done = 1'b0;
        ph   = (cur.phase > PH_STOP) ? PH_IDLE : cur.phase;

        if (ph == PH_IDLE) begin
            if (start_request) begin
                st.held_is_data = is_data;
                st.held_payload = payload;
                st.nack_flag    = 1'b0;
                st.byte_index   = BYTE_ADDR;
                st.tick_in_bit  = 2'd0;
                st.wait_count   = 8'd0;
                ph              = PH_START;
            end else begin
                busy   = 1'b0;
                st.scl = 1'b1;
                st.sda = 1'b1;
            end
        end
        st.phase = ph;

        case (ph)
            PH_IDLE: begin
            end
            PH_START: begin
                // first start tick keeps the previous SCL level
                case (st.tick_in_bit)
                    2'd0:    st.sda = 1'b1;
                    2'd1:    begin st.scl = 1'b1; st.sda = 1'b1; end
                    2'd2:    begin st.scl = 1'b1; st.sda = 1'b0; end
                    default: begin st.scl = 1'b0; st.sda = 1'b0; end
                endcase
                if (st.tick_in_bit == 2'd3) begin
                    st.byte_index  = BYTE_ADDR;
                    st.shift_byte  = cfg.device_address;
                    st.bit_index   = 3'd0;
                    st.tick_in_bit = 2'd0;
                    st.phase       = PH_BIT;
                end else begin
                    st.tick_in_bit = st.tick_in_bit + 2'd1;
                end
            end
            PH_BIT: begin
                // MSB first: bit 7 - bit_index, which is ~bit_index at three bits
                st.sda = st.shift_byte[~st.bit_index];
                st.scl = (st.tick_in_bit == 2'd1);
                if (st.tick_in_bit >= 2'd2) begin
                    st.tick_in_bit = 2'd0;
                    if (st.bit_index == 3'd7) begin
                        st.bit_index = 3'd0;
                        st.phase     = PH_ACK_REL;
                    end else begin
                        st.bit_index = st.bit_index + 3'd1;
                    end
                end else begin
                    st.tick_in_bit = st.tick_in_bit + 2'd1;
                end
            end
            PH_ACK_REL: begin
                st.scl        = 1'b0;
                st.sda        = 1'b1;
                st.wait_count = 8'd0;
                st.phase      = PH_ACK_POLL;
            end
            PH_ACK_POLL: begin
                st.scl = 1'b1;
                st.sda = 1'b1;
                if (!sda_in) begin
                    st.phase = PH_ACK_END;
                end else if (st.wait_count >= cfg.ack_timeout) begin
                    st.nack_flag = 1'b1;
                    st.phase     = PH_ACK_END;
                end else begin
                    st.wait_count = st.wait_count + 8'd1;
                end
            end
            PH_ACK_END: begin
                st.scl = 1'b0;
                st.sda = 1'b1;
                if (st.byte_index >= BYTE_LAST) begin
                    st.tick_in_bit = 2'd0;
                    st.phase       = PH_STOP;
                end else begin
                    st.byte_index  = st.byte_index + 2'd1;
                    st.shift_byte  = pick_byte(st.byte_index, st.held_is_data,
                                               st.held_payload, cfg.device_address);
                    st.bit_index   = 3'd0;
                    st.tick_in_bit = 2'd0;
                    st.phase       = PH_BIT;
                end
            end
            default: begin
                // stop condition
                case (st.tick_in_bit)
                    2'd0:    begin st.scl = 1'b0; st.sda = 1'b0; end
                    2'd1:    begin st.scl = 1'b1; st.sda = 1'b0; end
                    default: begin st.scl = 1'b1; st.sda = 1'b1; end
                endcase
                if (st.tick_in_bit >= 2'd2) begin
                    done           = 1'b1;
                    st.tick_in_bit = 2'd0;
                    st.byte_index  = BYTE_ADDR;
                    st.phase       = PH_IDLE;
                end else begin
                    st.tick_in_bit = st.tick_in_bit + 2'd1;
                end
            end
        endcase
    end

    assign nxt           = st;
    assign res.scl_level = st.scl;
    assign res.sda_level = st.sda;
    assign res.busy_res  = busy;
    assign res.nack_seen = st.nack_flag;
    assign res.done_res  = done;

endmodule

// ----- hw/rtl/i2c_display_byte_writer.sv -----
// Top level of the I2C display byte writer: tick state and result registers.
// Depends on i2cdbw_pkg, i2cdbw_cfg_regs and i2cdbw_tick_step.
//
//   channel | direction | handshake          | payload
//   s_      | in        | s_valid / s_ready  | start_request, is_data, payload, sda_in
//   m_      | out       | m_valid / m_ready  | scl_level, sda_level, busy_res,
//           |           |                    | nack_seen, done_res
//   cfg_    | in        | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One tick is accepted per cycle unless a stalled result blocks it; its result is
// registered when the tick is taken, in the same cycle that the tick state updates.
// A stalled result holds; a new tick is still taken in the cycle the held
// result leaves. Configuration writes are always taken.
// Reset (aresetn low, synchronous) sets the sequencer idle with SCL and SDA high.
`timescale 1ns / 1ps
module i2c_display_byte_writer
    import i2cdbw_pkg::*;
(
    input  logic                   aclk,
    input  logic                   aresetn,

    input  logic                   s_valid,
    output logic                   s_ready,
    input  logic                   s_start_request,
    input  logic                   s_is_data,
    input  logic [7:0]             s_payload,
    input  logic                   s_sda_in,

    output logic                   m_valid,
    input  logic                   m_ready,
    output logic                   m_scl_level,
    output logic                   m_sda_level,
    output logic                   m_busy_res,
    output logic                   m_nack_seen,
    output logic                   m_done_res,

    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [7:0]             cfg_data
);

    cfg_t         cfg;
    tick_state_t  state_reg;
    tick_state_t  state_next;
    tick_result_t res_reg;
    tick_result_t res_next;
    logic         m_valid_reg;
    logic         in_fire;

    assign cfg_ready = 1'b1;

    i2cdbw_cfg_regs u_cfg_regs (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    i2cdbw_tick_step u_tick_step (
        .cur           (state_reg),
        .cfg           (cfg),
        .start_request (s_start_request),
        .is_data       (s_is_data),
        .payload       (s_payload),
        .sda_in        (s_sda_in),
        .nxt           (state_next),
        .res           (res_next)
    );

    assign s_ready = !m_valid_reg || m_ready;
    assign in_fire = s_valid && s_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= STATE_RESET;
            m_valid_reg <= 1'b0;
        end else begin
            if (in_fire) begin
                state_reg <= state_next;
            end
            if (s_ready) begin
                m_valid_reg <= s_valid;
            end
        end
    end

    // result payload: load on every taken tick, hold otherwise
    always_ff @(posedge aclk) begin
        if (in_fire) begin
            res_reg <= res_next;
        end
    end

    assign m_valid     = m_valid_reg;
    assign m_scl_level = res_reg.scl_level;
    assign m_sda_level = res_reg.sda_level;
    assign m_busy_res  = res_reg.busy_res;
    assign m_nack_seen = res_reg.nack_seen;
    assign m_done_res  = res_reg.done_res;

endmodule

// ----- hw/rtl/i2cdbw_port_checker.sv -----
// Port-level checks for the I2C display byte writer, bound to the top level.
// Depends on the top-level port list only.
`timescale 1ns / 1ps
module i2cdbw_port_checker (
    input logic aclk,
    input logic aresetn,
    input logic s_ready,
    input logic m_valid,
    input logic m_ready,
    input logic m_scl_level,
    input logic m_sda_level,
    input logic m_busy_res,
    input logic m_nack_seen,
    input logic m_done_res
);

    // done marks the last stop tick, which is part of the transaction
    a_done_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_busy_res)
        else $error("done without busy");

    // stop ends with both lines released
    a_done_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_done_res |-> m_scl_level && m_sda_level)
        else $error("stop did not release the bus");

    // idle ticks keep the bus released
    a_idle_lines: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_busy_res |-> m_scl_level && m_sda_level)
        else $error("bus driven while idle");

    // held result must stay put
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_scl_level) && $stable(m_sda_level)
            && $stable(m_busy_res) && $stable(m_nack_seen) && $stable(m_done_res))
        else $error("stalled result changed");

    // an empty result register never blocks input
    a_ready_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_valid |-> s_ready)
        else $error("input stalled with empty output");

endmodule

bind i2c_display_byte_writer i2cdbw_port_checker u_port_checker (
    .aclk        (aclk),
    .aresetn     (aresetn),
    .s_ready     (s_ready),
    .m_valid     (m_valid),
    .m_ready     (m_ready),
    .m_scl_level (m_scl_level),
    .m_sda_level (m_sda_level),
    .m_busy_res  (m_busy_res),
    .m_nack_seen (m_nack_seen),
    .m_done_res  (m_done_res)
);

// ----- bench/i2c_display_byte_writer_test.sv -----
// Self-checking bench for the I2C display byte writer: directed and random bus ticks.
// Depends on i2cdbw_pkg and i2c_display_byte_writer; carries its own line-level predictor.
`timescale 1ns / 1ps
module i2c_display_byte_writer_test
    import i2cdbw_pkg::*;
();

    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_LOW  = 8'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED_HIGH = 8'hFF;

    logic       aclk = 1'b0;
    logic       aresetn = 1'b0;

    logic       s_valid = 1'b0;
    logic       s_ready;
    logic       s_start_request = 1'b0;
    logic       s_is_data = 1'b0;
    logic [7:0] s_payload = 8'd0;
    logic       s_sda_in = 1'b1;

    logic       m_valid;
    logic       m_ready = 1'b0;
    logic       m_scl_level;
    logic       m_sda_level;
    logic       m_busy_res;
    logic       m_nack_seen;
    logic       m_done_res;

    logic                   cfg_valid = 1'b0;
    logic                   cfg_ready;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [7:0]             cfg_data = 8'd0;

    i2c_display_byte_writer dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_start_request(s_start_request), .s_is_data(s_is_data),
        .s_payload(s_payload), .s_sda_in(s_sda_in),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_scl_level(m_scl_level), .m_sda_level(m_sda_level),
        .m_busy_res(m_busy_res), .m_nack_seen(m_nack_seen), .m_done_res(m_done_res),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // Predicted sequencer state and register copies
    logic [7:0] bus_address = ADDR_RESET;
    logic [7:0] bus_timeout = TIMEOUT_RESET;
    logic [2:0] p_phase = PH_IDLE;
    logic [1:0] p_byte = 2'd0;
    logic [2:0] p_bit = 3'd0;
    logic [1:0] p_tick = 2'd0;
    logic [7:0] p_shift = 8'd0;
    logic [7:0] p_wait = 8'd0;
    logic [7:0] p_payload = 8'd0;
    logic       p_is_data = 1'b0;
    logic       p_nack = 1'b0;
    logic       p_scl = 1'b1;
    logic       p_sda = 1'b1;

    tick_result_t expected_levels[$];

    int error_count = 0;
    int tick_count = 0;
    int write_count = 0;
    int nack_write_count = 0;
    int reg_write_count = 0;
    int burst_left = 0;
    int ready_run = 0;
    logic ready_stall = 1'b0;

    task automatic report_mismatch(input string msg);
        error_count++;
        if (error_count <= 40)
            $display("[%0t] MISMATCH: %s", $realtime, msg);
    endtask

    function automatic void load_next_byte();
        if (p_byte == BYTE_ADDR)
            p_shift = bus_address;
        else if (p_byte == BYTE_CTRL)
            p_shift = p_is_data ? CTRL_DATA : CTRL_CMD;
        else
            p_shift = p_payload;
        p_bit = 3'd0;
        p_tick = 2'd0;
        p_phase = PH_BIT;
    endfunction

    function automatic tick_result_t predict_bus_tick(input logic req, input logic dat,
                                                      input logic [7:0] pl, input logic sda_s);
        tick_result_t r;
        logic scl, sda, busy, done;
        scl = p_scl;
        sda = p_sda;
        busy = 1'b1;
        done = 1'b0;
        if (p_phase > PH_STOP)
            p_phase = PH_IDLE;
        if (p_phase == PH_IDLE) begin
            if (req) begin
                p_is_data = dat;
                p_payload = pl;
                p_nack = 1'b0;
                p_byte = 2'd0;
                p_tick = 2'd0;
                p_wait = 8'd0;
                p_phase = PH_START;
            end else begin
                busy = 1'b0;
                scl = 1'b1;
                sda = 1'b1;
            end
        end
        case (p_phase)
            PH_START: begin
                case (p_tick)
                    2'd0: sda = 1'b1;
                    2'd1: begin scl = 1'b1; sda = 1'b1; end
                    2'd2: begin scl = 1'b1; sda = 1'b0; end
                    default: begin scl = 1'b0; sda = 1'b0; end
                endcase
                if (p_tick == 2'd3) begin
                    p_byte = BYTE_ADDR;
                    load_next_byte();
                end else begin
                    p_tick = p_tick + 2'd1;
                end
            end
            PH_BIT: begin
                sda = p_shift[3'd7 - p_bit];
                scl = (p_tick == 2'd1);
                if (p_tick >= 2'd2) begin
                    p_tick = 2'd0;
                    if (p_bit == 3'd7) begin
                        p_bit = 3'd0;
                        p_phase = PH_ACK_REL;
                    end else begin
                        p_bit = p_bit + 3'd1;
                    end
                end else begin
                    p_tick = p_tick + 2'd1;
                end
            end
            PH_ACK_REL: begin
                scl = 1'b0;
                sda = 1'b1;
                p_wait = 8'd0;
                p_phase = PH_ACK_POLL;
            end
            PH_ACK_POLL: begin
                scl = 1'b1;
                sda = 1'b1;
                if (!sda_s) begin
                    p_phase = PH_ACK_END;
                end else if (p_wait >= bus_timeout) begin
                    p_nack = 1'b1;
                    p_phase = PH_ACK_END;
                end else begin
                    p_wait = p_wait + 8'd1;
                end
            end
            PH_ACK_END: begin
                scl = 1'b0;
                sda = 1'b1;
                if (p_byte >= BYTE_LAST) begin
                    p_tick = 2'd0;
                    p_phase = PH_STOP;
                end else begin
                    p_byte = p_byte + 2'd1;
                    load_next_byte();
                end
            end
            PH_STOP: begin
                case (p_tick)
                    2'd0: begin scl = 1'b0; sda = 1'b0; end
                    2'd1: begin scl = 1'b1; sda = 1'b0; end
                    default: begin scl = 1'b1; sda = 1'b1; end
                endcase
                if (p_tick >= 2'd2) begin
                    done = 1'b1;
                    p_tick = 2'd0;
                    p_byte = 2'd0;
                    p_phase = PH_IDLE;
                end else begin
                    p_tick = p_tick + 2'd1;
                end
            end
            default: ;
        endcase
        p_scl = scl;
        p_sda = sda;
        r.scl_level = scl;
        r.sda_level = sda;
        r.busy_res = busy;
        r.nack_seen = p_nack;
        r.done_res = done;
        return r;
    endfunction

    // Sender: bursts of back-to-back transactions separated by random gaps
    task automatic send_tick(input logic req, input logic dat, input logic [7:0] pl,
                             input logic sda);
        int gap;
        @(negedge aclk);
        if (burst_left == 0) begin
            gap = $urandom_range(0, 6);
            if (gap != 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            burst_left = $urandom_range(1, 48);
        end
        burst_left--;
        s_valid <= 1'b1;
        s_start_request <= req;
        s_is_data <= dat;
        s_payload <= pl;
        s_sda_in <= sda;
        do @(posedge aclk); while (!s_ready);
        expected_levels.push_back(predict_bus_tick(req, dat, pl, sda));
        tick_count++;
    endtask

    task automatic wait_drained();
        @(negedge aclk);
        s_valid <= 1'b0;
        burst_left = 0;
        while (expected_levels.size() != 0) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        wait_drained();
        @(negedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do @(posedge aclk); while (!cfg_ready);
        if (idx == REG_DEVICE_ADDRESS)
            bus_address = value;
        else if (idx == REG_ACK_TIMEOUT)
            bus_timeout = value;
        reg_write_count++;
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic idle_ticks(input int count);
        repeat (count) send_tick(1'b0, 1'($urandom_range(1)), 8'($urandom), 1'($urandom_range(1)));
    endtask

    // One full bus write; ack_pct sets how often the slave pulls SDA low per tick
    task automatic run_write(input logic dat, input logic [7:0] pl, input int ack_pct,
                             input logic busy_requests);
        logic req;
        send_tick(1'b1, dat, pl, 1'($urandom_range(1)));
        while (p_phase != PH_IDLE) begin
            req = busy_requests ? 1'($urandom_range(1)) : 1'b0;
            send_tick(req, 1'($urandom_range(1)), 8'($urandom),
                      ($urandom_range(99) < ack_pct) ? 1'b0 : 1'b1);
        end
    endtask

    task automatic test_idle_after_reset();
        idle_ticks(6);
    endtask

    task automatic test_command_write();
        run_write(1'b0, 8'hFF, 100, 1'b0);
    endtask

    task automatic test_data_write_with_busy_requests();
        run_write(1'b1, 8'h00, 100, 1'b1);
    endtask

    // Default timeout with no slave: all three slots time out, flag stays while idle
    task automatic test_default_timeout();
        run_write(1'b0, 8'h5A, 0, 1'b0);
        idle_ticks(4);
        run_write(1'b1, 8'hA5, 100, 1'b0);
    endtask

    task automatic test_register_extremes();
        write_reg(REG_DEVICE_ADDRESS, 8'h00);
        write_reg(REG_ACK_TIMEOUT, 8'h00);
        run_write(1'b1, 8'h01, 30, 1'b1);
        write_reg(REG_DEVICE_ADDRESS, 8'hFF);
        write_reg(REG_ACK_TIMEOUT, 8'hFF);
        run_write(1'b0, 8'h80, 50, 1'b0);
        // Unmapped indexes must leave both registers alone
        write_reg(REG_UNMAPPED_LOW, 8'h3C);
        write_reg(REG_UNMAPPED_HIGH, 8'h01);
        run_write(1'b1, 8'h7E, 80, 1'b0);
    endtask

    task automatic random_phase(input logic [7:0] addr, input logic [7:0] timeout,
                                input int ticks);
        int stop_at;
        int ack_pct;
        write_reg(REG_DEVICE_ADDRESS, addr);
        write_reg(REG_ACK_TIMEOUT, timeout);
        stop_at = tick_count + ticks;
        while (tick_count < stop_at) begin
            if ($urandom_range(3) == 0) begin
                idle_ticks($urandom_range(1, 5));
            end else begin
                case ($urandom_range(4))
                    0: ack_pct = 100;
                    1: ack_pct = 90;
                    2: ack_pct = 50;
                    3: ack_pct = 10;
                    default: ack_pct = (timeout <= 8'd16) ? 0 : 10;
                endcase
                run_write(1'($urandom_range(1)), 8'($urandom), ack_pct, 1'($urandom_range(1)));
            end
        end
    endtask

    task automatic test_random_traffic();
        random_phase(8'($urandom), 8'd1, 40);
        random_phase(8'($urandom), 8'($urandom_range(1, 8)), 40);
        random_phase(8'hFF, 8'hFF, 40);
        random_phase(8'h00, 8'd0, 40);
    endtask

    // Receiver: ready runs and stalls of random length
    always @(negedge aclk) begin
        if (ready_run == 0) begin
            ready_stall = ($urandom_range(3) == 0);
            ready_run = ready_stall ? $urandom_range(1, 5) : $urandom_range(1, 40);
        end
        ready_run--;
        m_ready <= !ready_stall;
    end

    task automatic compare_field(input string name, input logic got, input logic exp);
        if (got !== exp)
            report_mismatch($sformatf("tick result %s got %b expected %b", name, got, exp));
    endtask

    always @(posedge aclk) begin
        tick_result_t exp;
        if (aresetn && m_valid && m_ready) begin
            if (expected_levels.size() == 0) begin
                report_mismatch("result transaction with no tick outstanding");
            end else begin
                exp = expected_levels.pop_front();
                compare_field("scl_level", m_scl_level, exp.scl_level);
                compare_field("sda_level", m_sda_level, exp.sda_level);
                compare_field("busy_res", m_busy_res, exp.busy_res);
                compare_field("nack_seen", m_nack_seen, exp.nack_seen);
                compare_field("done_res", m_done_res, exp.done_res);
                if (exp.done_res) begin
                    write_count++;
                    if (exp.nack_seen)
                        nack_write_count++;
                end
            end
        end
    end

    initial begin
        #5_000_000;
        $display("Timed out with %0d ticks outstanding", expected_levels.size());
        $display("*** FAILED ***");
        $finish;
    end

    initial begin
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_idle_after_reset();
        test_command_write();
        test_data_write_with_busy_requests();
        test_default_timeout();
        test_register_extremes();
        test_random_traffic();

        wait_drained();
        repeat (4) @(posedge aclk);
        if (expected_levels.size() != 0)
            report_mismatch($sformatf("%0d tick results never arrived", expected_levels.size()));

        $display("Ran %0d bus ticks: %0d complete writes, %0d of them with an ack timeout,",
                 tick_count, write_count, nack_write_count);
        $display("across %0d register writes including address and timeout extremes.",
                 reg_write_count);
        if (error_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
